FILE: sv/lrcfe_pkg.sv
// Package for the LRC command frame encoder: item, job and state types,
// frame constants, error codes and the LRC helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lrcfe_pkg;

  localparam logic [7:0]  SOF_BYTE         = 8'h11;
  localparam int unsigned FRAME_OVERHEAD   = 10;
  localparam int unsigned FRAME_BUFFER_DEF = 64;
  localparam int unsigned IDX_W            = 4;

  localparam logic [IDX_W-1:0] HDR_LAST_IDX      = IDX_W'(FRAME_OVERHEAD - 2);
  localparam logic [IDX_W-1:0] HDR_LAST_IDX_NOPL = IDX_W'(FRAME_OVERHEAD - 1);

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LENGTH   = 2'd1;
  localparam logic [1:0] ERR_NO_FRAME = 2'd2;

  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    JOB_HEADER,
    JOB_SINGLE,
    JOB_BYTE_LRC
  } job_kind_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] command_code;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic        frame_open;
    logic [15:0] bytes_remaining;
    logic [7:0]  payload_sum;
  } state_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [IDX_W-1:0] last_idx;
    logic [15:0]      cmd;
    logic [15:0]      len;
    logic [7:0]       data;
    logic [7:0]       lrc;
    logic [1:0]       err;
  } job_t;

  // Two's complement of an 8-bit sum.
  function automatic logic [7:0] lrc_of(input logic [7:0] sum);
    return 8'(~sum + 8'd1);
  endfunction

endpackage
`default_nettype wire

FILE: sv/lrcfe_if.sv
// Valid/ready channel interfaces for the frame encoder input and result words.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lrcfe_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] command_code;
  logic [15:0] payload_length;
  logic [7:0]  payload_byte;

  modport source (output valid, mode, command_code, payload_length, payload_byte,
                  input ready);
  modport sink   (input valid, mode, command_code, payload_length, payload_byte,
                  output ready);
endinterface

interface lrcfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  logic [1:0] error_code;

  modport source (output valid, frame_byte, frame_end, error_code, input ready);
  modport sink   (input valid, frame_byte, frame_end, error_code, output ready);
endinterface
`default_nettype wire

FILE: sv/lrcfe_decode.sv
// Item decoder: from one input word and the frame state, builds the result job
// and the next frame state. Depends on lrcfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lrcfe_decode
  import lrcfe_pkg::*;
#(
  parameter int unsigned FRAME_BUFFER = FRAME_BUFFER_DEF
)
(
  input  item_t  item,
  input  state_t cur,
  output state_t nxt,
  output job_t   job
);

  logic [16:0] len_total;
  logic        len_bad;
  logic [7:0]  hdr_sum;
  logic [7:0]  sum_upd;
  logic [15:0] rem_upd;

  assign len_total = {1'b0, item.payload_length} + 17'(FRAME_OVERHEAD);
  assign len_bad   = len_total > 17'(FRAME_BUFFER);
  assign hdr_sum   = 8'(item.command_code[15:8] + item.command_code[7:0]
                        + item.payload_length[15:8] + item.payload_length[7:0]);
  assign sum_upd   = 8'(cur.payload_sum + item.payload_byte);
  assign rem_upd   = 16'(cur.bytes_remaining - 16'd1);

  always_comb begin
    nxt          = cur;
    job.kind     = JOB_SINGLE;
    job.last_idx = '0;
    job.cmd      = item.command_code;
    job.len      = item.payload_length;
    job.data     = 8'h00;
    job.lrc      = lrc_of(hdr_sum);
    job.err      = ERR_NONE;
    if (item.mode == MODE_START) begin
      if (len_bad) begin
        nxt     = '0;
        job.err = ERR_LENGTH;
      end else begin
        job.kind        = JOB_HEADER;
        nxt.payload_sum = 8'h00;
        if (item.payload_length == 16'd0) begin
          job.last_idx        = HDR_LAST_IDX_NOPL;
          nxt.frame_open      = 1'b0;
          nxt.bytes_remaining = 16'd0;
        end else begin
          job.last_idx        = HDR_LAST_IDX;
          nxt.frame_open      = 1'b1;
          nxt.bytes_remaining = item.payload_length;
        end
      end
    end else if (!cur.frame_open) begin
      job.err = ERR_NO_FRAME;
    end else begin
      job.data            = item.payload_byte;
      nxt.bytes_remaining = rem_upd;
      nxt.payload_sum     = sum_upd;
      if (rem_upd == 16'd0) begin
        job.kind        = JOB_BYTE_LRC;
        job.last_idx    = IDX_W'(1);
        job.lrc         = lrc_of(sum_upd);
        nxt.frame_open  = 1'b0;
        nxt.payload_sum = 8'h00;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/lrcfe_emit.sv
// Result emitter: holds one job and steps through its result words, one per
// handshake on the result channel. Depends on lrcfe_pkg and lrcfe_out_if.
`timescale 1ns / 1ps
`default_nettype none
module lrcfe_emit
  import lrcfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  job_t        job,
  output logic        free,
  lrcfe_out_if.source out_ch
);

  logic             job_valid_r, job_valid_nxt;
  job_t             job_r, job_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last;
  logic             fire;

  assign last = idx_r == job_r.last_idx;
  assign fire = job_valid_r && out_ch.ready;
  assign free = !job_valid_r || (out_ch.ready && last);

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    if (load) begin
      job_valid_nxt = 1'b1;
      job_nxt       = job;
      idx_nxt       = '0;
    end else if (fire && last) begin
      job_valid_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = IDX_W'(idx_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
    end
    job_r <= job_nxt;
    idx_r <= idx_nxt;
  end

  // Pick the current word of the held job.
  always_comb begin
    out_ch.frame_byte = 8'h00;
    out_ch.frame_end  = last;
    out_ch.error_code = job_r.err;
    case (job_r.kind)
      JOB_HEADER: begin
        case (idx_r)
          4'd0:    out_ch.frame_byte = SOF_BYTE;
          4'd1:    out_ch.frame_byte = lrc_of(SOF_BYTE);
          4'd2:    out_ch.frame_byte = job_r.cmd[15:8];
          4'd3:    out_ch.frame_byte = job_r.cmd[7:0];
          4'd6:    out_ch.frame_byte = job_r.len[15:8];
          4'd7:    out_ch.frame_byte = job_r.len[7:0];
          4'd8:    out_ch.frame_byte = job_r.lrc;
          default: out_ch.frame_byte = 8'h00;
        endcase
      end
      JOB_BYTE_LRC: begin
        out_ch.frame_byte = last ? job_r.lrc : job_r.data;
      end
      default: begin
        out_ch.frame_byte = job_r.data;
      end
    endcase
  end

  assign out_ch.valid = job_valid_r;

endmodule
`default_nettype wire

FILE: sv/lrc_command_frame_encoder.sv
// Top level of the LRC command frame encoder: input word register, frame
// state, decoder and result emitter. Depends on lrcfe_pkg, lrcfe_if, lrcfe_decode, lrcfe_emit.
//
// Usage:
//  - in_ch carries input words: mode 0 starts a frame (command_code,
//    payload_length), mode 1 carries one payload_byte. A word is taken at a
//    rising edge with valid and ready both high.
//  - out_ch carries result words (frame_byte, frame_end, error_code).
//    frame_end marks the last result word caused by an input word.
//  - A start word yields nine header words (ten with an empty payload, the
//    tenth being the zero payload LRC). A payload word yields one word, or
//    two on the last byte (byte then payload LRC). Errors yield one word.
//  - Path: an input word passes through the input register, then the
//    emitter's job register, before its first result word can be taken.
//  - Throughput: one result word per cycle while out_ch is ready, set by the
//    emitter's single output port; payload words therefore stream at one per
//    cycle, and the emitter takes a new job only once the last word of the
//    current one is taken.
//  - When out_ch stalls, the emitter holds its word, one more input word
//    waits in the input register, and in_ch.ready drops after that.
//  - Synchronous reset clears the frame state (no frame open) and empties
//    both the input register and the emitter.
`timescale 1ns / 1ps
`default_nettype none
module lrc_command_frame_encoder
  import lrcfe_pkg::*;
#(
  parameter int unsigned FRAME_BUFFER = FRAME_BUFFER_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  lrcfe_in_if.sink    in_ch,
  lrcfe_out_if.source out_ch
);

  logic   in_valid_r, in_valid_nxt;
  item_t  item_r, item_nxt;
  state_t state_r, state_nxt, state_dec;
  job_t   job;
  logic   emit_free;
  logic   take;
  logic   accept;

  // Move the held word into the emitter as soon as it frees up.
  assign take        = in_valid_r && emit_free;
  assign in_ch.ready = !in_valid_r || emit_free;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    item_nxt     = item_r;
    state_nxt    = state_r;
    if (take) begin
      state_nxt    = state_dec;
      in_valid_nxt = 1'b0;
    end
    if (accept) begin
      in_valid_nxt            = 1'b1;
      item_nxt.mode           = in_ch.mode;
      item_nxt.command_code   = in_ch.command_code;
      item_nxt.payload_length = in_ch.payload_length;
      item_nxt.payload_byte   = in_ch.payload_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      in_valid_r <= in_valid_nxt;
      state_r    <= state_nxt;
    end
    item_r <= item_nxt;
  end

  lrcfe_decode #(
    .FRAME_BUFFER (FRAME_BUFFER)
  ) u_decode (
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_dec),
    .job  (job)
  );

  lrcfe_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (take),
    .job    (job),
    .free   (emit_free),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

FILE: bench/tb.sv
// Self-checking bench for lrc_command_frame_encoder: random valid/ready traffic on both channels,
// with each result word checked against a frame model kept inside the bench.
// Depends on lrcfe_pkg (item type, codes, frame constants), lrcfe_if and the encoder RTL.
`timescale 1ns / 1ps
module tb;
  import lrcfe_pkg::*;

  // Stop when nothing moves on either channel for this many cycles. The longest
  // legal quiet stretch is the receiver hold-off plus the pipeline delay.
  localparam int IDLE_LIMIT   = 1000;
  localparam int HOLD_CYCLES  = 70;
  localparam int RANDOM_WORDS = 110;
  localparam int MAX_LEN      = FRAME_BUFFER_DEF - FRAME_OVERHEAD;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
    logic [1:0] error_code;
  } frame_word_t;

  logic clk = 1'b0;
  logic rst_n;

  lrcfe_in_if  in_ch ();
  lrcfe_out_if out_ch ();

  lrc_command_frame_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Words waiting to be sent, and result words the model says must come back.
  item_t       pending_words[$];
  frame_word_t expected_words[$];

  int total_words;
  int words_accepted;
  int words_popped;
  int results_checked;
  int fail_count;
  int hold_trigger;
  int input_stalls;
  int frames_started;
  int payload_sent;
  int error_words;

  // Frame model state.
  logic        frame_open_q;
  logic [15:0] remain_q;
  logic [7:0]  sum_q;

  // ---------------------------------------------------------------------------
  // Frame model
  // ---------------------------------------------------------------------------

  // LRC: two's complement of the 8-bit sum of the covered bytes.
  function automatic logic [7:0] checksum_of(input logic [7:0] sum);
    return 8'(9'h100 - {1'b0, sum});
  endfunction

  task automatic push_word(input logic [7:0] b, input logic last, input logic [1:0] err);
    expected_words.push_back('{b, last, err});
  endtask

  // Work out the result words that one accepted input word causes.
  task automatic encode_word(input item_t w);
    logic [7:0] hdr [0:9];
    logic [7:0] hsum;
    int         n;
    if (w.mode == MODE_START) begin
      if (32'(w.payload_length) + FRAME_OVERHEAD > FRAME_BUFFER_DEF) begin
        // Length too long: drop any open frame and flag one error word.
        frame_open_q = 1'b0;
        remain_q     = '0;
        sum_q        = '0;
        error_words++;
        push_word(8'h00, 1'b1, ERR_LENGTH);
      end else begin
        // A start inside an open frame simply abandons it.
        frames_started++;
        hdr[0] = SOF_BYTE;
        hdr[1] = checksum_of(SOF_BYTE);
        hdr[2] = w.command_code[15:8];
        hdr[3] = w.command_code[7:0];
        hdr[4] = 8'h00;
        hdr[5] = 8'h00;
        hdr[6] = w.payload_length[15:8];
        hdr[7] = w.payload_length[7:0];
        hsum   = 8'(hdr[2] + hdr[3] + hdr[4] + hdr[5] + hdr[6] + hdr[7]);
        hdr[8] = checksum_of(hsum);
        hdr[9] = 8'h00;
        sum_q  = '0;
        if (w.payload_length == 16'd0) begin
          // Empty payload: append the zero payload LRC, frame closes at once.
          n            = 10;
          frame_open_q = 1'b0;
          remain_q     = '0;
        end else begin
          n            = 9;
          frame_open_q = 1'b1;
          remain_q     = w.payload_length;
        end
        for (int i = 0; i < n; i++)
          push_word(hdr[i], i == n - 1, ERR_NONE);
      end
    end else if (!frame_open_q) begin
      // Stray payload byte: flag it, leave the state alone.
      error_words++;
      push_word(8'h00, 1'b1, ERR_NO_FRAME);
    end else begin
      payload_sent++;
      sum_q    = 8'(sum_q + w.payload_byte);
      remain_q = remain_q - 16'd1;
      if (remain_q != 16'd0) begin
        push_word(w.payload_byte, 1'b1, ERR_NONE);
      end else begin
        // Last payload byte: the byte, then the payload LRC closes the frame.
        push_word(w.payload_byte, 1'b0, ERR_NONE);
        push_word(checksum_of(sum_q), 1'b1, ERR_NONE);
        frame_open_q = 1'b0;
        sum_q        = '0;
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count < 20)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------

  // Fields that the block ignores for a given mode still get random values.
  task automatic queue_start(input logic [15:0] cmd, input logic [15:0] len);
    item_t w;
    w.mode           = MODE_START;
    w.command_code   = cmd;
    w.payload_length = len;
    w.payload_byte   = 8'($urandom_range(0, 255));
    pending_words.push_back(w);
  endtask

  task automatic queue_byte(input logic [7:0] b);
    item_t w;
    w.mode           = MODE_PAYLOAD;
    w.command_code   = 16'($urandom_range(0, 65535));
    w.payload_length = 16'($urandom_range(0, 65535));
    w.payload_byte   = b;
    pending_words.push_back(w);
  endtask

  task automatic queue_noise();
    item_t w;
    w.mode           = logic'($urandom_range(0, 1));
    w.command_code   = 16'($urandom_range(0, 65535));
    w.payload_length = 16'($urandom_range(0, 65535));
    w.payload_byte   = 8'($urandom_range(0, 255));
    pending_words.push_back(w);
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps in between. An offered word
  // is held stable until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : sender
    static logic offering   = 1'b0;
    static int   burst_left = 0;
    static int   gap_left   = 0;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      // Drop the word that was taken at the last rising edge.
      if (words_accepted != words_popped) begin
        void'(pending_words.pop_front());
        words_popped++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          offering = 1'b1;
          if (burst_left > 0)
            burst_left--;
          if (burst_left == 0) begin
            // Pick the next burst; half the time run on without a gap.
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
      in_ch.valid <= offering;
      if (offering) begin
        in_ch.mode           <= pending_words[0].mode;
        in_ch.command_code   <= pending_words[0].command_code;
        in_ch.payload_length <= pending_words[0].payload_length;
        in_ch.payload_byte   <= pending_words[0].payload_byte;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: rotate through ready patterns (always, random, mostly stalled,
  // alternating), plus one long hold-off while the sender keeps offering so
  // the encoder backs up and drops in_ch.ready.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : receiver
    static int   rx_cycle       = 0;
    static int   hold_left      = 0;
    static logic long_hold_done = 1'b0;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (!long_hold_done && words_accepted >= hold_trigger) begin
        hold_left      = HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case ((rx_cycle / 48) % 4)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= logic'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ((rx_cycle % 2) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check result words first, then predict from the input word taken
  // at the same edge (its results must first pass the input register and the emitter).
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    frame_word_t got;
    frame_word_t want;
    item_t       w;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.frame_byte, out_ch.frame_end, out_ch.error_code};
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word byte=%02h end=%0b err=%0d",
                                    got.frame_byte, got.frame_end, got.error_code));
        end else begin
          want = expected_words.pop_front();
          results_checked++;
          if (got !== want)
            report_mismatch($sformatf(
              "word %0d: got byte=%02h end=%0b err=%0d, want byte=%02h end=%0b err=%0d",
              results_checked, got.frame_byte, got.frame_end, got.error_code,
              want.frame_byte, want.frame_end, want.error_code));
        end
      end
      if (in_ch.valid && !in_ch.ready)
        input_stalls++;
      if (in_ch.valid && in_ch.ready) begin
        w = '{in_ch.mode, in_ch.command_code, in_ch.payload_length, in_ch.payload_byte};
        encode_word(w);
        words_accepted++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles in which neither channel moves a word.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    static int idle_cycles = 0;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles, %0d results still expected",
                 IDLE_LIMIT, expected_words.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int directed_words;
    int len;
    int kind;
    int sent;
    rst_n                = 1'b0;
    frame_open_q         = 1'b0;
    remain_q             = '0;
    sum_q                = '0;
    words_accepted       = 0;
    words_popped         = 0;
    results_checked      = 0;
    fail_count           = 0;
    input_stalls         = 0;
    frames_started       = 0;
    payload_sent         = 0;
    error_words          = 0;

    // Directed part: stray bytes, empty payload, length limits, abandoned
    // frame, zero LRC, length error closing an open frame.
    queue_byte(8'h00);                 // payload byte right after reset
    queue_start(16'h0000, 16'd0);      // empty payload, ten header words
    queue_start(16'hFFFF, 16'hFFFF);   // largest length, rejected
    queue_start(16'h1234, 16'(MAX_LEN + 1));
    queue_start(16'hA55A, 16'(MAX_LEN));  // longest accepted length...
    queue_byte(8'hFF);
    queue_byte(8'h00);
    queue_start(16'h5AA5, 16'd3);      // ...abandoned by a new start
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_byte(8'h80);                 // last byte, LRC follows
    queue_byte(8'hFF);                 // frame already closed
    queue_start(16'hFFFF, 16'd1);
    queue_byte(8'h00);                 // payload LRC of zero
    queue_start(16'h00FF, 16'd2);
    queue_byte(8'h7F);
    queue_start(16'hFF00, 16'h8000);   // length error closes the open frame
    queue_byte(8'h01);                 // so this one is stray
    queue_start(16'hC3C3, 16'd0);
    directed_words = pending_words.size();
    hold_trigger   = directed_words + 40;

    // Random part: mostly well-formed frames with random content, the rest
    // truncated frames, frames with a trailing stray byte and pure noise.
    while (pending_words.size() < directed_words + RANDOM_WORDS) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) queue_noise();
      end else begin
        case ($urandom_range(0, 11))
          0:       len = MAX_LEN;
          1:       len = $urandom_range(0, MAX_LEN);
          default: len = $urandom_range(0, 6);
        endcase
        queue_start(16'($urandom_range(0, 65535)), 16'(len));
        // Truncate now and then; the next start abandons the frame.
        sent = (kind == 1 && len > 0) ? $urandom_range(0, len - 1) : len;
        repeat (sent) queue_byte(8'($urandom_range(0, 255)));
        if (kind == 2)
          queue_byte(8'($urandom_range(0, 255)));
      end
    end
    total_words = pending_words.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be taken and every expected result to arrive.
    while (words_accepted != total_words) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    // Give stray extra results a chance to show up.
    repeat (16) @(negedge clk);

    $display("Sent %0d words: %0d frames, %0d payload bytes, %0d error cases.",
             total_words, frames_started, payload_sent, error_words);
    $display("Checked %0d result words; input held off for %0d cycles by backpressure.",
             results_checked, input_stalls);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/lrcfe_pkg.sv
sv/lrcfe_if.sv
sv/lrcfe_decode.sv
sv/lrcfe_emit.sv
sv/lrc_command_frame_encoder.sv
bench/tb.sv
